>>> sv/sbm_pkg.sv
// Shared types, widths and codes for the serial bank mapper.
package sbm_pkg;

    // Field widths.
    localparam int unsigned AddrW     = 16;
    localparam int unsigned DataW     = 8;
    localparam int unsigned OffsetW   = 19;
    localparam int unsigned PrgCountW = 6;
    localparam int unsigned ChrCountW = 5;
    localparam int unsigned BankW     = 5;
    localparam int unsigned CfgDataW  = 6;

    // Access codes.
    localparam logic [1:0] OP_CPU_READ   = 2'd0;
    localparam logic [1:0] OP_CPU_WRITE  = 2'd1;
    localparam logic [1:0] OP_VIDEO_READ = 2'd2;

    // ROM select codes.
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_PRG  = 2'd1;
    localparam logic [1:0] SEL_CHR  = 2'd2;

    // Program banking modes; the two codes below 2 both mean 32K mode.
    localparam logic [1:0] PMODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PMODE_FIX_LAST  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_PRG_COUNT = 1'b0;
    localparam logic CFG_CHR_COUNT = 1'b1;

    // Mapper registers as seen by the address translation.
    typedef struct packed {
        logic [1:0]       mirror;
        logic [1:0]       prg_mode;
        logic             chr_4k;
        logic [BankW-1:0] chr_bank_lo;
        logic [BankW-1:0] chr_bank_hi;
        logic [BankW-1:0] prg_bank;
    } sbm_state_t;

    // Bank counts with zero already mapped to one.
    typedef struct packed {
        logic [PrgCountW-1:0] prg_count;
        logic [ChrCountW-1:0] chr_count;
    } sbm_cfg_t;

endpackage

>>> sv/sbm_regs.sv
// Serial load register, bank and control registers, and configuration registers.
module sbm_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [sbm_pkg::CfgDataW-1:0] cfg_data,
    input  logic                        upd_en,
    input  logic [1:0]                  opcode,
    input  logic [sbm_pkg::AddrW-1:0]   bus_address,
    input  logic [sbm_pkg::DataW-1:0]   write_data,
    output sbm_pkg::sbm_state_t         state,
    output sbm_pkg::sbm_cfg_t           cfg,
    output logic [1:0]                  mirror_next
);
    import sbm_pkg::*;

    localparam logic [5:0] ShiftInit = 6'h20;

    // Register targets picked by address bits 14:13.
    localparam logic [1:0] TGT_CONTROL = 2'd0;
    localparam logic [1:0] TGT_CHR_LO  = 2'd1;
    localparam logic [1:0] TGT_CHR_HI  = 2'd2;

    logic [PrgCountW-1:0] prg_count_reg;
    logic [ChrCountW-1:0] chr_count_reg;
    logic [5:0]           serial_reg;
    logic [5:0]           serial_next;
    logic [5:0]           shifted;
    sbm_state_t           state_reg;
    sbm_state_t           state_next;
    logic [BankW-1:0]     value;
    logic [PrgCountW-1:0] prg_lim;
    logic [ChrCountW-1:0] chr_lim;
    logic [ChrCountW:0]   chr_twice;
    logic [BankW-1:0]     prg_clamped;
    logic [BankW-1:0]     chr_clamped;

    // Effective counts: a zero count behaves as one bank.
    assign cfg.prg_count = (prg_count_reg == '0) ? PrgCountW'(1) : prg_count_reg;
    assign cfg.chr_count = (chr_count_reg == '0) ? ChrCountW'(1) : chr_count_reg;

    // Clamp a loaded bank value that lies at or beyond the available banks.
    assign prg_lim     = cfg.prg_count - PrgCountW'(1);
    assign chr_lim     = cfg.chr_count - ChrCountW'(1);
    assign chr_twice   = {cfg.chr_count, 1'b0};
    assign shifted     = {write_data[0], serial_reg[5:1]};
    assign value       = shifted[5:1];
    assign prg_clamped = ({1'b0, value} >= prg_lim + PrgCountW'(1)) ? prg_lim[BankW-1:0]
                                                                   : value;
    assign chr_clamped = ({1'b0, value} >= chr_twice) ? chr_lim : value;

    // Serial load: bit 7 restarts, the fifth bit commits to a register.
    always_comb begin
        serial_next = serial_reg;
        state_next = state_reg;
        if (upd_en && opcode == OP_CPU_WRITE) begin
            if (write_data[7]) begin
                serial_next = ShiftInit;
            end else begin
                serial_next = shifted;
                if (shifted[0]) begin
                    serial_next = ShiftInit;
                    case (bus_address[14:13])
                        TGT_CONTROL: begin
                            state_next.mirror   = value[1:0];
                            state_next.prg_mode = value[3:2];
                            state_next.chr_4k   = value[4];
                        end
                        TGT_CHR_LO: begin
                            state_next.chr_bank_lo = chr_clamped;
                        end
                        TGT_CHR_HI: begin
                            state_next.chr_bank_hi = chr_clamped;
                        end
                        default: begin
                            state_next.prg_bank = prg_clamped;
                        end
                    endcase
                end
            end
        end
    end

    assign mirror_next = state_next.mirror;
    assign state       = state_reg;

    // State and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_count_reg         <= PrgCountW'(16);
            chr_count_reg         <= ChrCountW'(16);
            serial_reg            <= ShiftInit;
            state_reg.mirror      <= 2'd0;
            state_reg.prg_mode    <= PMODE_FIX_LAST;
            state_reg.chr_4k      <= 1'b0;
            state_reg.chr_bank_lo <= '0;
            state_reg.chr_bank_hi <= '0;
            state_reg.prg_bank    <= '0;
        end else begin
            serial_reg <= serial_next;
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PRG_COUNT: prg_count_reg <= cfg_data[PrgCountW-1:0];
                    CFG_CHR_COUNT: prg_count_reg <= prg_count_reg;
                    default:       prg_count_reg <= prg_count_reg;
                endcase
                if (cfg_index == CFG_CHR_COUNT) begin
                    chr_count_reg <= cfg_data[ChrCountW-1:0];
                end
            end
        end
    end

endmodule

>>> sv/sbm_xlate.sv
// Translation of a bus address into a program or video ROM offset.
module sbm_xlate (
    input  logic [1:0]                  opcode,
    input  logic [sbm_pkg::AddrW-1:0]   bus_address,
    input  sbm_pkg::sbm_state_t         state,
    input  sbm_pkg::sbm_cfg_t           cfg,
    output logic [sbm_pkg::OffsetW-1:0] rom_offset,
    output logic [1:0]                  rom_select
);
    import sbm_pkg::*;

    logic [PrgCountW-1:0] last_bank;
    logic [BankW-1:0]     prg_bank_sel;
    logic [OffsetW-1:0]   prg_offset;
    logic [BankW-1:0]     chr_bank_sel;
    logic [OffsetW-1:0]   chr_offset;
    logic                 upper_half;

    assign last_bank  = cfg.prg_count - PrgCountW'(1);
    assign upper_half = bus_address[15] & bus_address[14];

    // Program window: 32K banking or 16K banking with one half fixed.
    always_comb begin
        prg_bank_sel = state.prg_bank;
        case (state.prg_mode)
            PMODE_FIX_FIRST: begin
                prg_bank_sel = upper_half ? state.prg_bank : '0;
                prg_offset   = {prg_bank_sel, bus_address[13:0]};
            end
            PMODE_FIX_LAST: begin
                prg_bank_sel = upper_half ? last_bank[BankW-1:0] : state.prg_bank;
                prg_offset   = {prg_bank_sel, bus_address[13:0]};
            end
            default: begin
                prg_offset = {state.prg_bank[BankW-1:1], bus_address[14:0]};
            end
        endcase
    end

    // Video window: two 4K banks or one 8K bank.
    always_comb begin
        chr_bank_sel = (bus_address[15:12] == 4'd0) ? state.chr_bank_lo : state.chr_bank_hi;
        if (state.chr_4k) begin
            chr_offset = {2'b00, chr_bank_sel, bus_address[11:0]};
        end else begin
            chr_offset = {2'b00, state.chr_bank_lo[BankW-1:1], 13'd0}
                       + {3'b000, bus_address};
        end
    end

    // Pick the result by access kind; writes and unused codes give no ROM access.
    always_comb begin
        case (opcode)
            OP_CPU_READ: begin
                rom_offset = prg_offset;
                rom_select = SEL_PRG;
            end
            OP_VIDEO_READ: begin
                rom_offset = chr_offset;
                rom_select = SEL_CHR;
            end
            default: begin
                rom_offset = '0;
                rom_select = SEL_NONE;
            end
        endcase
    end

endmodule

>>> sv/serial_bank_mapper.sv
// Top level of the serial bank mapper: input register, mapper logic, result register.
// Each accepted beat is one bus access (CPU read, CPU write or video read) and yields
// exactly one result beat carrying the ROM offset, ROM select and current mirroring.
// The block takes one beat per cycle while the result register is free or being emptied;
// a beat is held in the input register, where the serial register update and the address
// translation are done, and then in the result register until taken. Register updates
// from a CPU write are seen by the very next beat. Configuration writes (bank counts) are
// meant to be made only while no beat is in flight.
module serial_bank_mapper (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [sbm_pkg::CfgDataW-1:0] cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [sbm_pkg::AddrW-1:0]    s_bus_address,
    input  logic [sbm_pkg::DataW-1:0]    s_write_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sbm_pkg::OffsetW-1:0]  m_rom_offset,
    output logic [1:0]                   m_rom_select,
    output logic [1:0]                   m_mirroring
);
    import sbm_pkg::*;

    logic               in_valid_reg;
    logic [1:0]         in_opcode_reg;
    logic [AddrW-1:0]   in_addr_reg;
    logic [DataW-1:0]   in_data_reg;
    logic               out_valid_reg;
    logic [OffsetW-1:0] out_offset_reg;
    logic [1:0]         out_select_reg;
    logic [1:0]         out_mirror_reg;
    logic               advance;
    sbm_state_t         state;
    sbm_cfg_t           cfg;
    logic [1:0]         mirror_next;
    logic [OffsetW-1:0] offset;
    logic [1:0]         select;

    // The held beat moves on when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg <= s_opcode;
            in_addr_reg   <= s_bus_address;
            in_data_reg   <= s_write_data;
        end
    end

    sbm_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .upd_en      (advance),
        .opcode      (in_opcode_reg),
        .bus_address (in_addr_reg),
        .write_data  (in_data_reg),
        .state       (state),
        .cfg         (cfg),
        .mirror_next (mirror_next)
    );

    sbm_xlate u_xlate (
        .opcode      (in_opcode_reg),
        .bus_address (in_addr_reg),
        .state       (state),
        .cfg         (cfg),
        .rom_offset  (offset),
        .rom_select  (select)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_offset_reg <= offset;
            out_select_reg <= select;
            out_mirror_reg <= mirror_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_rom_offset = out_offset_reg;
    assign m_rom_select = out_select_reg;
    assign m_mirroring  = out_mirror_reg;

endmodule
